// File: hdl/json_stream_validator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the JSON stream validator
// Shorthand for clocked implication checks with an active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef JSON_STREAM_VALIDATOR_MACROS_SVH
`define JSON_STREAM_VALIDATOR_MACROS_SVH

// Same-cycle implication.
`define JSV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define JSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/jsv_pkg.sv
// ----------------------------------------------------------------------------
// jsv_pkg
// Shared types and codes of the JSON stream validator.
// ----------------------------------------------------------------------------
package jsv_pkg;

  localparam logic [2:0] ST_BUSY   = 3'd0;
  localparam logic [2:0] ST_ACCEPT = 3'd1;
  localparam logic [2:0] ST_SYNTAX = 3'd2;
  localparam logic [2:0] ST_DEPTH  = 3'd3;
  localparam logic [2:0] ST_NODES  = 3'd4;

  localparam logic [1:0] REG_MAX_DEPTH = 2'd0;
  localparam logic [1:0] REG_MAX_NODES = 2'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Everything one input word produces: up to four decoded bytes.
  typedef struct packed {
    logic [2:0]      status;
    logic [2:0]      n_emit;
    logic [3:0][7:0] bytes;
    logic            key;
    logic [6:0]      depth;
  } pkt_t;

endpackage

// File: hdl/jsv_front.sv
// ----------------------------------------------------------------------------
// jsv_front
// Byte parser: one input word per cycle, produces one result packet.
// ----------------------------------------------------------------------------
module jsv_front #(
  parameter int STACK_DEPTH = 64,
  parameter int COUNT_BITS  = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_end_i,
  output logic            pkt_valid_o,
  output jsv_pkg::pkt_t   pkt_o
);
  import jsv_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    M_VAL, M_ARR_OPEN, M_OBJ_OPEN, M_KEY, M_COLON, M_AFTER, M_DONE, M_LIT,
    M_STR, M_ESC, M_HEX0, M_HEX1, M_HEX2, M_HEX3, M_LBS, M_LU,
    M_LHEX0, M_LHEX1, M_LHEX2, M_LHEX3,
    N_MINUS, N_ZERO, N_INT, N_FRAC0, N_FRAC, N_EXP0, N_EXPS, N_EXP
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [STACK_DEPTH-1:0] stk_q, stk_d;
  logic [SP_W-1:0]        sp_q, sp_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [4:0]             lit_q, lit_d;
  logic [15:0]            hex_q, hex_d, acc;
  logic [9:0]             hs_q, hs_d;
  logic [2:0]             err_q, err_d;
  logic                   key_q, key_d;
  logic [5:0]             max_depth_q;
  logic [15:0]            max_nodes_q;

  logic [7:0]      c;
  logic            ws, dig, reproc, do_start;
  logic [4:0]      hv;
  logic [2:0]      n_emit;
  logic [3:0][7:0] eb;
  logic [1:0]      lid;
  logic [2:0]      lidx;
  logic [20:0]     cp_pair;
  logic [2:0]      status;

  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b inside {[8'h30:8'h39]}) r = {1'b0, 4'(b - 8'h30)};
    else if (b inside {[8'h61:8'h66]}) r = {1'b0, 4'(b - 8'h57)};
    else if (b inside {[8'h41:8'h46]}) r = {1'b0, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] id, input logic [2:0] ix);
    logic [7:0] r;
    r = 8'h00;
    case (id)
      2'd0: case (ix) 3'd0: r = "n"; 3'd1: r = "u"; 3'd2: r = "l"; 3'd3: r = "l";
              default: r = 8'h00; endcase
      2'd1: case (ix) 3'd0: r = "t"; 3'd1: r = "r"; 3'd2: r = "u"; 3'd3: r = "e";
              default: r = 8'h00; endcase
      2'd2: case (ix) 3'd0: r = "f"; 3'd1: r = "a"; 3'd2: r = "l"; 3'd3: r = "s";
              3'd4: r = "e"; default: r = 8'h00; endcase
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // UTF-8 encoding of a code point; the byte count sits in the top bits.
  function automatic logic [34:0] utf8_enc(input logic [20:0] cp);
    logic [2:0]      n;
    logic [3:0][7:0] b;
    b = '0;
    if (cp <= 21'h7f) begin
      n = 3'd1; b[0] = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      n = 3'd2; b[0] = {3'b110, cp[10:6]}; b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      n = 3'd3; b[0] = {4'b1110, cp[15:12]}; b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
    end else begin
      n = 3'd4; b[0] = {5'b11110, cp[20:18]}; b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]}; b[3] = {2'b10, cp[5:0]};
    end
    return {n, b};
  endfunction

  assign c       = in_byte_i;
  assign ws      = (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
  assign dig     = c inside {[8'h30:8'h39]};
  assign hv      = hex_val(c);
  assign acc     = {hex_q[11:0], hv[3:0]};
  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
  assign lid     = lit_q[4:3];
  assign lidx    = lit_q[2:0];
  assign cp_pair = 21'h10000 + {1'b0, hs_q, acc[9:0]};

  always_comb begin
    mode_d   = mode_q;
    stk_d    = stk_q;
    sp_d     = sp_q;
    cnt_d    = cnt_q;
    lit_d    = lit_q;
    hex_d    = hex_q;
    hs_d     = hs_q;
    err_d    = err_q;
    key_d    = key_q;
    n_emit   = 3'd0;
    eb       = '0;
    reproc   = 1'b0;
    do_start = 1'b0;
    if (err_q == ST_BUSY) begin
      case (mode_q)
        M_VAL: if (!ws) do_start = 1'b1;
        M_ARR_OPEN: begin
          if (!ws) begin
            if (c == "]") begin
              sp_d   = sp_q - 1'b1;
              stk_d  = {1'b0, stk_q[STACK_DEPTH-1:1]};
              mode_d = (sp_q == SP_W'(1)) ? M_DONE : M_AFTER;
            end else begin
              do_start = 1'b1;
            end
          end
        end
        M_OBJ_OPEN, M_KEY: begin
          if (!ws) begin
            if (c == "}" && mode_q == M_OBJ_OPEN) begin
              sp_d   = sp_q - 1'b1;
              stk_d  = {1'b0, stk_q[STACK_DEPTH-1:1]};
              mode_d = (sp_q == SP_W'(1)) ? M_DONE : M_AFTER;
            end else if (c == "\"") begin
              key_d  = 1'b1;
              mode_d = M_STR;
            end else begin
              err_d = ST_SYNTAX;
            end
          end
        end
        M_COLON: begin
          if (!ws) begin
            if (c == ":") mode_d = M_VAL;
            else err_d = ST_SYNTAX;
          end
        end
        M_AFTER, M_DONE: reproc = 1'b1;
        M_LIT: begin
          if (lid == 2'd3 || lidx >= ((lid == 2'd2) ? 3'd5 : 3'd4) ||
              c != lit_char(lid, lidx)) begin
            err_d = ST_SYNTAX;
          end else begin
            lit_d = {lid, lidx + 3'd1};
            if ((lidx + 3'd1) == ((lid == 2'd2) ? 3'd5 : 3'd4)) begin
              mode_d = (sp_q == '0) ? M_DONE : M_AFTER;
            end
          end
        end
        M_STR: begin
          if (c == "\"") begin
            if (key_q) begin
              key_d  = 1'b0;
              mode_d = M_COLON;
            end else begin
              mode_d = (sp_q == '0) ? M_DONE : M_AFTER;
            end
          end else if (c < 8'h20) begin
            err_d = ST_SYNTAX;
          end else if (c == "\\") begin
            mode_d = M_ESC;
          end else begin
            n_emit = 3'd1;
            eb[0]  = c;
          end
        end
        M_ESC: begin
          mode_d = M_STR;
          n_emit = 3'd1;
          case (c)
            "\"":    eb[0] = 8'h22;
            "\\":    eb[0] = 8'h5c;
            "/":     eb[0] = 8'h2f;
            "b":     eb[0] = 8'h08;
            "f":     eb[0] = 8'h0c;
            "n":     eb[0] = 8'h0a;
            "r":     eb[0] = 8'h0d;
            "t":     eb[0] = 8'h09;
            "u": begin
              n_emit = 3'd0;
              hex_d  = '0;
              mode_d = M_HEX0;
            end
            default: begin
              n_emit = 3'd0;
              mode_d = M_ESC;
              err_d  = ST_SYNTAX;
            end
          endcase
        end
        M_HEX0, M_HEX1, M_HEX2, M_LHEX0, M_LHEX1, M_LHEX2: begin
          if (hv[4]) begin
            err_d = ST_SYNTAX;
          end else begin
            hex_d  = acc;
            mode_d = mode_e'(mode_q + 5'd1);
          end
        end
        M_HEX3: begin
          if (hv[4]) begin
            err_d = ST_SYNTAX;
          end else begin
            hex_d = acc;
            if (acc inside {[16'hd800:16'hdbff]}) begin
              hs_d   = acc[9:0];
              mode_d = M_LBS;
            end else if (acc inside {[16'hdc00:16'hdfff]}) begin
              err_d = ST_SYNTAX;
            end else begin
              {n_emit, eb} = utf8_enc({5'd0, acc});
              mode_d       = M_STR;
            end
          end
        end
        M_LHEX3: begin
          if (hv[4]) begin
            err_d = ST_SYNTAX;
          end else begin
            hex_d = acc;
            if (!(acc inside {[16'hdc00:16'hdfff]})) begin
              err_d = ST_SYNTAX;
            end else begin
              {n_emit, eb} = utf8_enc(cp_pair);
              mode_d       = M_STR;
            end
          end
        end
        M_LBS: begin
          if (c == "\\") mode_d = M_LU;
          else err_d = ST_SYNTAX;
        end
        M_LU: begin
          if (c == "u") begin
            hex_d  = '0;
            mode_d = M_LHEX0;
          end else begin
            err_d = ST_SYNTAX;
          end
        end
        N_MINUS: begin
          if (c == "0") mode_d = N_ZERO;
          else if (c inside {[8'h31:8'h39]}) mode_d = N_INT;
          else err_d = ST_SYNTAX;
        end
        N_ZERO, N_INT, N_FRAC: begin
          if (dig && mode_q != N_ZERO) begin
            mode_d = mode_q;
          end else if (c == "." && mode_q != N_FRAC) begin
            mode_d = N_FRAC0;
          end else if (c == "e" || c == "E") begin
            mode_d = N_EXP0;
          end else begin
            reproc = 1'b1;
          end
        end
        N_FRAC0: begin
          if (dig) mode_d = N_FRAC;
          else err_d = ST_SYNTAX;
        end
        N_EXP0: begin
          if (c == "+" || c == "-") mode_d = N_EXPS;
          else if (dig) mode_d = N_EXP;
          else err_d = ST_SYNTAX;
        end
        N_EXPS: begin
          if (dig) mode_d = N_EXP;
          else err_d = ST_SYNTAX;
        end
        N_EXP: if (!dig) reproc = 1'b1;
        default: err_d = ST_SYNTAX;
      endcase

      // The byte after a value, including the byte that ends a number.
      if (reproc && !ws) begin
        if (sp_q == '0) begin
          err_d = ST_SYNTAX;
        end else if (c == ",") begin
          mode_d = stk_q[0] ? M_KEY : M_VAL;
        end else if ((c == "]" && !stk_q[0]) || (c == "}" && stk_q[0])) begin
          sp_d   = sp_q - 1'b1;
          stk_d  = {1'b0, stk_q[STACK_DEPTH-1:1]};
          mode_d = (sp_q == SP_W'(1)) ? M_DONE : M_AFTER;
        end else begin
          err_d = ST_SYNTAX;
        end
      end else if (reproc) begin
        mode_d = (sp_q == '0) ? M_DONE : M_AFTER;
      end

      if (do_start) begin
        if (32'(sp_q) > 32'(max_depth_q)) begin
          err_d = ST_DEPTH;
        end else begin
          cnt_d = cnt_inc;
          if (32'(cnt_inc) > 32'(max_nodes_q)) begin
            err_d = ST_NODES;
          end else if (c == "n" || c == "t" || c == "f") begin
            lit_d  = {(c == "n") ? 2'd0 : (c == "t") ? 2'd1 : 2'd2, 3'd1};
            mode_d = M_LIT;
          end else if (c == "\"") begin
            key_d  = 1'b0;
            mode_d = M_STR;
          end else if (c == "[" || c == "{") begin
            if (32'(sp_q) >= STACK_DEPTH) begin
              err_d = ST_DEPTH;
            end else begin
              stk_d  = {stk_q[STACK_DEPTH-2:0], c == "{"};
              sp_d   = sp_q + 1'b1;
              mode_d = (c == "{") ? M_OBJ_OPEN : M_ARR_OPEN;
            end
          end else if (c == "-") begin
            mode_d = N_MINUS;
          end else if (c == "0") begin
            mode_d = N_ZERO;
          end else if (c inside {[8'h31:8'h39]}) begin
            mode_d = N_INT;
          end else begin
            err_d = ST_SYNTAX;
          end
        end
      end
    end

    status = err_d;
    if (in_end_i && err_d == ST_BUSY) begin
      status = (sp_d == '0 && (mode_d == M_DONE || mode_d == N_ZERO || mode_d == N_INT ||
                mode_d == N_FRAC || mode_d == N_EXP)) ? ST_ACCEPT : ST_SYNTAX;
    end
  end

  assign pkt_valid_o   = in_valid_i;
  assign pkt_o.status  = status;
  assign pkt_o.n_emit  = n_emit;
  assign pkt_o.bytes   = eb;
  assign pkt_o.key     = key_q;
  assign pkt_o.depth   = 7'(sp_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= M_VAL;
      sp_q        <= '0;
      cnt_q       <= '0;
      lit_q       <= '0;
      hex_q       <= '0;
      hs_q        <= '0;
      err_q       <= ST_BUSY;
      key_q       <= 1'b0;
      max_depth_q <= 6'd32;
      max_nodes_q <= 16'd12000;
    end else begin
      if (cfg_valid_i && cfg_index_i == REG_MAX_DEPTH) max_depth_q <= cfg_data_i[5:0];
      if (cfg_valid_i && cfg_index_i == REG_MAX_NODES) max_nodes_q <= cfg_data_i;
      if (in_valid_i) begin
        if (in_end_i) begin
          mode_q <= M_VAL;
          sp_q   <= '0;
          cnt_q  <= '0;
          lit_q  <= '0;
          hex_q  <= '0;
          hs_q   <= '0;
          err_q  <= ST_BUSY;
          key_q  <= 1'b0;
        end else begin
          mode_q <= mode_d;
          sp_q   <= sp_d;
          cnt_q  <= cnt_d;
          lit_q  <= lit_d;
          hex_q  <= hex_d;
          hs_q   <= hs_d;
          err_q  <= err_d;
          key_q  <= key_d;
        end
      end
    end
  end

  // Container stack as a shift line: the innermost container sits in bit 0.
  always_ff @(posedge clk_i) begin
    if (in_valid_i) stk_q <= stk_d;
  end

endmodule

// File: hdl/jsv_fifo.sv
// ----------------------------------------------------------------------------
// jsv_fifo
// Short packet queue between the parser and the result serializer.
// ----------------------------------------------------------------------------
`include "json_stream_validator_macros.svh"

module jsv_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsv_pkg::pkt_t push_data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output jsv_pkg::pkt_t head_o
);
  import jsv_pkg::*;

  pkt_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      count_q <= count_q + (QPTR_W + 1)'(push_i) - (QPTR_W + 1)'(pop_i);
    end
  end

  `JSV_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= (QPTR_W + 1)'(QUEUE_DEPTH))
  `JSV_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, pop_i, count_q != '0)
  `JSV_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + 1'b1)

endmodule

// File: hdl/jsv_back.sv
// ----------------------------------------------------------------------------
// jsv_back
// Result serializer: sends each packet as one to four output words.
// ----------------------------------------------------------------------------
module jsv_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  jsv_pkg::pkt_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    status_o,
  output logic          dvalid_o,
  output logic [7:0]    dbyte_o,
  output logic          key_o,
  output logic [6:0]    depth_o,
  output logic          last_o
);
  import jsv_pkg::*;

  logic [1:0] idx_q;
  logic       has;

  assign has         = (head_i.n_emit != 3'd0);
  assign last_o      = !has || ({1'b0, idx_q} == head_i.n_emit - 3'd1);
  assign out_valid_o = !empty_i;
  assign pop_o       = out_valid_o && out_ready_i && last_o;
  assign status_o    = head_i.status;
  assign dvalid_o    = has;
  assign dbyte_o     = has ? head_i.bytes[idx_q] : 8'h00;
  assign key_o       = has && head_i.key;
  assign depth_o     = head_i.depth;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      idx_q <= last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

// File: hdl/json_stream_validator.sv
// ----------------------------------------------------------------------------
// json_stream_validator
// Streaming strict-JSON syntax checker with string unescaping.
// ----------------------------------------------------------------------------
// The block takes one document byte per input word and, when the output side
// keeps up, accepts a new byte every cycle. Each byte produces one output word,
// or one word per decoded string byte (up to four for a surrogate pair), and
// the output sends one word per cycle while the receiver is ready. A four-entry
// queue between the parser and the serializer absorbs the resulting bursts;
// input stalls only when the queue is full. Every word carries the running
// status and nesting depth; the word marked tlast is the last one caused by its
// input byte. An error is latched and reported on every word until the byte
// flagged as the end of the document, which gives the final verdict and
// restarts the parser. The two limit registers are to be written through the
// configuration channel only while idle; the block itself does not enforce this.
module json_stream_validator #(
  parameter int STACK_DEPTH = 64,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel; index 0 is max_depth, index 1 is max_nodes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_doc
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] status, [10:3] decoded_byte,
                                      // [17:11] nest_depth, [23:18] zero
  output logic [1:0]  m_axis_tuser,   // [0] decoded_valid, [1] in_key
  output logic        m_axis_tlast    // run_last
);
  import jsv_pkg::*;

  pkt_t       pkt, head;
  logic       pkt_valid, full, empty, pop;
  logic [2:0] status;
  logic       dvalid, key;
  logic [7:0] dbyte;
  logic [6:0] depth;

  // Configuration writes are always taken.
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;

  jsv_front #(
    .STACK_DEPTH (STACK_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid && !full),
    .in_byte_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .pkt_valid_o (pkt_valid),
    .pkt_o       (pkt)
  );

  jsv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pkt_valid),
    .push_data_i (pkt),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  jsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .dvalid_o    (dvalid),
    .dbyte_o     (dbyte),
    .key_o       (key),
    .depth_o     (depth),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, depth, dbyte, status};
  assign m_axis_tuser = {key, dvalid};

endmodule

// File: test/json_stream_validator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_stream_validator_checker
// Watches the channels of the JSON stream validator, tracks the parser
// state on every accepted input word and compares each output word with
// the oldest predicted word.
// ----------------------------------------------------------------------------
module json_stream_validator_checker
  import jsv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [4:0] {
    P_VAL, P_ARR_OPEN, P_OBJ_OPEN, P_KEY, P_COLON, P_AFTER, P_DONE, P_LIT,
    P_STR, P_ESC, P_HEX0, P_HEX1, P_HEX2, P_HEX3, P_LBS, P_LU,
    P_LHEX0, P_LHEX1, P_LHEX2, P_LHEX3,
    P_NEG, P_ZERO, P_INT, P_FRAC0, P_FRAC, P_EXP0, P_EXPS, P_EXP
  } parse_e;

  typedef struct packed {
    logic [2:0] status;
    logic       dvalid;
    logic [7:0] dbyte;
    logic       key;
    logic [6:0] depth;
    logic       last;
  } word_t;

  word_t       expected_words[$];
  int          fails;

  logic [5:0]  lim_depth;
  logic [15:0] lim_nodes;
  parse_e      mode;
  logic [63:0] open_kind;   // 1 marks an object
  logic [6:0]  sp;
  logic [15:0] nvals;
  logic [1:0]  lit_id;
  logic [2:0]  lit_idx;
  logic [15:0] hexacc;
  logic [9:0]  hi_sur;
  logic [2:0]  err;
  logic        keyf;
  logic [7:0]  dec_bytes[$];
  logic        dec_keys[$];

  assign fail_count_o = fails;
  assign pending_o    = expected_words.size();

  function automatic void clear_doc();
    mode = P_VAL; open_kind = '0; sp = '0; nvals = '0; lit_id = '0;
    lit_idx = '0; hexacc = '0; hi_sur = '0; err = ST_BUSY; keyf = 1'b0;
  endfunction

  function automatic void flag(logic [2:0] code);
    if (err == ST_BUSY) err = code;
  endfunction

  function automatic void put(logic [7:0] b);
    if (dec_bytes.size() < 4) begin
      dec_bytes = {dec_bytes, b};
      dec_keys  = {dec_keys, keyf};
    end
  endfunction

  // UTF-8 encoding of one code point.
  function automatic void put_cp(logic [20:0] cp);
    if (cp <= 21'h7f) begin
      put(cp[7:0]);
    end else if (cp <= 21'h7ff) begin
      put(8'hc0 | cp[10:6]);
      put(8'h80 | cp[5:0]);
    end else if (cp <= 21'hffff) begin
      put(8'he0 | cp[15:12]);
      put(8'h80 | cp[11:6]);
      put(8'h80 | cp[5:0]);
    end else begin
      put(8'hf0 | cp[20:18]);
      put(8'h80 | cp[17:12]);
      put(8'h80 | cp[11:6]);
      put(8'h80 | cp[5:0]);
    end
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] id, logic [2:0] idx);
    string s;
    s = (id == 0) ? "null" : (id == 1) ? "true" : "false";
    return (idx < s.len()) ? s[idx] : 8'h00;
  endfunction

  function automatic void end_value();
    mode = (sp == 0) ? P_DONE : P_AFTER;
  endfunction

  function automatic void close_one();
    if (sp > 0) sp--;
    end_value();
  endfunction

  function automatic void open_one(logic is_obj);
    if (sp >= 64) begin
      flag(ST_DEPTH);
      return;
    end
    open_kind[sp[5:0]] = is_obj;
    sp++;
    mode = is_obj ? P_OBJ_OPEN : P_ARR_OPEN;
  endfunction

  function automatic void begin_value(logic [7:0] c);
    if (sp > lim_depth) begin
      flag(ST_DEPTH);
      return;
    end
    if (nvals != 16'hffff) nvals++;
    if (nvals > lim_nodes) begin
      flag(ST_NODES);
      return;
    end
    case (c)
      "n": begin lit_id = 0; lit_idx = 1; mode = P_LIT; end
      "t": begin lit_id = 1; lit_idx = 1; mode = P_LIT; end
      "f": begin lit_id = 2; lit_idx = 1; mode = P_LIT; end
      "\"": begin keyf = 1'b0; mode = P_STR; end
      "[": open_one(1'b0);
      "{": open_one(1'b1);
      "-": mode = P_NEG;
      "0": mode = P_ZERO;
      default: begin
        if (c >= "1" && c <= "9") mode = P_INT;
        else flag(ST_SYNTAX);
      end
    endcase
  endfunction

  function automatic int nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void take_hex(logic [7:0] c);
    int d;
    d = nibble(c);
    if (d < 0) begin
      flag(ST_SYNTAX);
      return;
    end
    hexacc = {hexacc[11:0], d[3:0]};
    if (mode == P_HEX3) begin
      if (hexacc >= 16'hd800 && hexacc <= 16'hdbff) begin
        hi_sur = hexacc[9:0];
        mode = P_LBS;
      end else if (hexacc >= 16'hdc00 && hexacc <= 16'hdfff) begin
        flag(ST_SYNTAX);
      end else begin
        put_cp({5'd0, hexacc});
        mode = P_STR;
      end
    end else if (mode == P_LHEX3) begin
      if (hexacc < 16'hdc00 || hexacc > 16'hdfff) begin
        flag(ST_SYNTAX);
        return;
      end
      put_cp(21'h10000 + {hi_sur, hexacc[9:0]});
      mode = P_STR;
    end else begin
      mode = parse_e'(mode + 1);
    end
  endfunction

  // Returns 1 when a number ended and the byte must be taken again.
  function automatic bit take_byte(logic [7:0] c);
    case (mode)
      P_VAL: if (!blank(c)) begin_value(c);
      P_ARR_OPEN: begin
        if (!blank(c)) begin
          if (c == "]") close_one();
          else begin_value(c);
        end
      end
      P_OBJ_OPEN, P_KEY: begin
        if (!blank(c)) begin
          if (c == "}" && mode == P_OBJ_OPEN) close_one();
          else if (c == "\"") begin keyf = 1'b1; mode = P_STR; end
          else flag(ST_SYNTAX);
        end
      end
      P_COLON: begin
        if (!blank(c)) begin
          if (c == ":") mode = P_VAL;
          else flag(ST_SYNTAX);
        end
      end
      P_AFTER: begin
        if (!blank(c)) begin
          if (sp == 0) flag(ST_SYNTAX);
          else if (c == ",") mode = open_kind[sp - 1] ? P_KEY : P_VAL;
          else if ((c == "]" && !open_kind[sp - 1]) || (c == "}" && open_kind[sp - 1]))
            close_one();
          else flag(ST_SYNTAX);
        end
      end
      P_DONE: if (!blank(c)) flag(ST_SYNTAX);
      P_LIT: begin
        if (c != lit_char(lit_id, lit_idx)) begin
          flag(ST_SYNTAX);
        end else begin
          lit_idx++;
          if (lit_idx == ((lit_id == 2) ? 5 : 4)) end_value();
        end
      end
      P_STR: begin
        if (c == "\"") begin
          if (keyf) begin keyf = 1'b0; mode = P_COLON; end
          else end_value();
        end else if (c < 8'h20) flag(ST_SYNTAX);
        else if (c == "\\") mode = P_ESC;
        else put(c);
      end
      P_ESC: begin
        mode = P_STR;
        case (c)
          "\"": put("\"");
          "\\": put("\\");
          "/":  put("/");
          "b":  put(8'h08);
          "f":  put(8'h0c);
          "n":  put(8'h0a);
          "r":  put(8'h0d);
          "t":  put(8'h09);
          "u":  begin hexacc = '0; mode = P_HEX0; end
          default: begin mode = P_ESC; flag(ST_SYNTAX); end
        endcase
      end
      P_HEX0, P_HEX1, P_HEX2, P_HEX3, P_LHEX0, P_LHEX1, P_LHEX2, P_LHEX3:
        take_hex(c);
      P_LBS: if (c == "\\") mode = P_LU; else flag(ST_SYNTAX);
      P_LU: begin
        if (c == "u") begin hexacc = '0; mode = P_LHEX0; end
        else flag(ST_SYNTAX);
      end
      P_NEG: begin
        if (c == "0") mode = P_ZERO;
        else if (c >= "1" && c <= "9") mode = P_INT;
        else flag(ST_SYNTAX);
      end
      P_ZERO, P_INT, P_FRAC: begin
        if (digit(c) && mode != P_ZERO) return 1'b0;
        if (c == "." && mode != P_FRAC) begin mode = P_FRAC0; return 1'b0; end
        if (c == "e" || c == "E") begin mode = P_EXP0; return 1'b0; end
        end_value();
        return 1'b1;
      end
      P_FRAC0: if (digit(c)) mode = P_FRAC; else flag(ST_SYNTAX);
      P_EXP0: begin
        if (c == "+" || c == "-") mode = P_EXPS;
        else if (digit(c)) mode = P_EXP;
        else flag(ST_SYNTAX);
      end
      P_EXPS: if (digit(c)) mode = P_EXP; else flag(ST_SYNTAX);
      P_EXP: begin
        if (digit(c)) return 1'b0;
        end_value();
        return 1'b1;
      end
      default: flag(ST_SYNTAX);
    endcase
    return 1'b0;
  endfunction

  // Works out every output word one document byte causes.
  function automatic void predict_byte(logic [7:0] c, logic eod);
    logic [2:0] st;
    int         n;
    word_t      w;
    dec_bytes.delete();
    dec_keys.delete();
    if (err == ST_BUSY) begin
      if (take_byte(c) && err == ST_BUSY) void'(take_byte(c));
    end
    st = err;
    if (eod && st == ST_BUSY) begin
      st = (sp == 0 && (mode inside {P_DONE, P_ZERO, P_INT, P_FRAC, P_EXP}))
           ? ST_ACCEPT : ST_SYNTAX;
    end
    n = (dec_bytes.size() == 0) ? 1 : dec_bytes.size();
    for (int k = 0; k < n; k++) begin
      w.status = st;
      w.dvalid = dec_bytes.size() != 0;
      w.dbyte  = w.dvalid ? dec_bytes[k] : 8'h00;
      w.key    = w.dvalid ? dec_keys[k] : 1'b0;
      w.depth  = sp;
      w.last   = (k == n - 1);
      expected_words = {expected_words, w};
    end
    if (eod) clear_doc();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_t got, want;
    if (!rst_ni) begin
      lim_depth = 6'd32;
      lim_nodes = 16'd12000;
      clear_doc();
      expected_words.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_MAX_DEPTH) lim_depth = cfg_data_i[5:0];
        else if (cfg_index_i == REG_MAX_NODES) lim_nodes = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) predict_byte(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) begin
        got = '{m_tdata_i[2:0], m_tuser_i[0], m_tdata_i[10:3], m_tuser_i[1],
                m_tdata_i[17:11], m_tlast_i};
        if (expected_words.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t: unexpected output word %p", $realtime, got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("%0t: output word mismatch, expected %p, got %p",
                       $realtime, want, got);
          end
        end
      end
    end
  end

endmodule

// File: test/json_stream_validator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_stream_validator_tb
// Feeds the validator with directed and random JSON documents under several
// limit settings, with random gaps on both streams and one long output stall.
// The checker beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module json_stream_validator_tb;
  import jsv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_MAX_DEPTH;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          bytes_sent = 0;
  bit          hold_request = 1'b0;   // asks the receiver for a long stall
  logic [7:0]  doc[$];                // document under construction

  always #6 clk_i = ~clk_i;

  json_stream_validator dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  json_stream_validator_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tlast_i(s_axis_tlast),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser), .m_tlast_i(m_axis_tlast),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Receiver: random stalls, stretches at full rate, and one long hold-off
  // on request so that the internal queue fills and the input stalls.
  initial begin
    int stall;
    int burst;
    stall = 0;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 29) == 0) begin
        burst = $urandom_range(20, 60);
        m_axis_tready <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        m_axis_tready <= (stall == 0);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Appends one byte to the document under construction.
  function automatic void append_byte(logic [7:0] b);
    doc = {doc, b};
  endfunction

  // One document byte; valid stays high between words when no gap is taken.
  task automatic send_byte(input logic [7:0] b, input logic eod);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eod;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_doc();
    foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1);
    doc.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    send_doc();
  endtask

  // Quiesce the input and wait until every predicted word came out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic void add(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic void add_blanks();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: append_byte(" ");
        1: append_byte(8'h09);
        2: append_byte(8'h0d);
        default: append_byte(8'h0a);
      endcase
    end
  endfunction

  function automatic void add_hex(logic [15:0] v);
    string digits;
    logic [3:0] d;
    for (int i = 3; i >= 0; i--) begin
      d = v[i*4 +: 4];
      digits = $urandom_range(0, 1) ? "0123456789abcdef" : "0123456789ABCDEF";
      append_byte(digits[d]);
    end
  endfunction

  function automatic void add_digits(int lo, int hi);
    repeat ($urandom_range(lo, hi)) append_byte(8'($urandom_range("0", "9")));
  endfunction

  function automatic void add_number();
    if ($urandom_range(0, 2) == 0) append_byte("-");
    if ($urandom_range(0, 3) == 0) append_byte("0");
    else begin
      append_byte(8'($urandom_range("1", "9")));
      add_digits(0, 3);
    end
    if ($urandom_range(0, 2) == 0) begin
      append_byte(".");
      add_digits(1, 3);
    end
    if ($urandom_range(0, 3) == 0) begin
      append_byte($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: append_byte("+");
        1: append_byte("-");
        default: ;
      endcase
      add_digits(1, 2);
    end
  endfunction

  function automatic void add_string();
    logic [7:0] c;
    append_byte("\"");
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 9))
        0: begin
          append_byte("\\");
          case ($urandom_range(0, 7))
            0: append_byte("\""); 1: append_byte("\\"); 2: append_byte("/");
            3: append_byte("b");  4: append_byte("f");  5: append_byte("n");
            6: append_byte("r");  default: append_byte("t");
          endcase
        end
        1: begin
          append_byte("\\");
          append_byte("u");
          case ($urandom_range(0, 2))
            0: add_hex(16'($urandom_range(0, 16'h7ff)));
            1: add_hex(16'($urandom_range(16'he000, 16'hffff)));
            default: add_hex(16'($urandom_range(0, 16'hd7ff)));
          endcase
        end
        2: begin
          append_byte("\\");
          append_byte("u");
          add_hex(16'($urandom_range(16'hd800, 16'hdbff)));
          append_byte("\\");
          append_byte("u");
          add_hex(16'($urandom_range(16'hdc00, 16'hdfff)));
        end
        default: begin
          do c = 8'($urandom_range(8'h20, 8'hff)); while (c == "\"" || c == "\\");
          append_byte(c);
        end
      endcase
    end
    append_byte("\"");
  endfunction

  function automatic void add_value(int lvl);
    int kind;
    int n;
    kind = (lvl >= 3) ? $urandom_range(0, 2) : $urandom_range(0, 4);
    add_blanks();
    case (kind)
      0: begin
        case ($urandom_range(0, 2))
          0: add("null"); 1: add("true"); default: add("false");
        endcase
      end
      1: add_number();
      2: add_string();
      3: begin
        n = $urandom_range(0, 3);
        append_byte("[");
        add_blanks();
        for (int i = 0; i < n; i++) begin
          if (i > 0) append_byte(",");
          add_value(lvl + 1);
        end
        append_byte("]");
      end
      default: begin
        n = $urandom_range(0, 3);
        append_byte("{");
        add_blanks();
        for (int i = 0; i < n; i++) begin
          if (i > 0) append_byte(",");
          add_blanks();
          add_string();
          add_blanks();
          append_byte(":");
          add_value(lvl + 1);
        end
        append_byte("}");
      end
    endcase
    add_blanks();
  endfunction

  // Mostly well-formed documents; the rest are corrupted, cut short,
  // noise, or nested deep enough to run into the depth limits.
  task automatic random_docs(input int budget);
    int r;
    int n;
    while (budget > 0) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        add_value(0);
      end else if (r < 16) begin
        add_value(0);
        doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (r < 18) begin
        add_value(0);
        if (doc.size() > 1) doc = doc[0:$urandom_range(0, doc.size() - 2)];
      end else if (r < 19) begin
        repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 66);
        repeat (n) append_byte("[");
        repeat (n) append_byte("]");
      end
      budget -= doc.size();
      send_doc();
    end
  endtask

  initial begin
    logic [5:0]  depth_set[5] = '{6'd32, 6'd1, 6'd63, 6'd2, 6'd0};
    logic [15:0] nodes_set[5] = '{16'd12000, 16'd1, 16'd65535, 16'd5, 16'd0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < 5; p++) begin
      if (p == 4) begin
        depth_set[p] = 6'($urandom_range(1, 63));
        nodes_set[p] = 16'($urandom_range(1, 40));
      end
      write_reg(REG_MAX_DEPTH, {10'd0, depth_set[p]});
      write_reg(REG_MAX_NODES, nodes_set[p]);
      case (p)
        0: begin
          // Literals, number forms, containers, every escape, surrogate pairs
          // and the usual faults: lone low surrogate, bad escape, stray
          // closer, leading zero and a document cut off in a literal.
          send_text("null");
          send_text("true");
          send_text(" false\t");
          send_text("-0.5e+3");
          send_text("0E-1");
          send_text("\r\n[ 1 ,{\"k\":\"v\"}, [] ,{ }]\n");
          send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\\u00e9\\u4E2D\\ud83d\\ude00\"");
          send_text("{\"\\u07FF\":\"\\uFFFF\"}");
          send_text("\"\\udc00\"");
          send_text("\"\\x\"");
          send_text("[}");
          send_text("01");
          send_text("tru");
        end
        1: begin
          send_text("[[[1]]]");
          send_text("[1]");
        end
        2: begin
          hold_request = 1'b1;
          for (int i = 0; i < 65; i++) append_byte("[");
          send_doc();
        end
        default: ;
      endcase
      random_docs(35);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
